/* src/rpbb_pkg.sv */
// Shared types, constants and saturation helper for the projected bounding box block.
`default_nettype none

package rpbb_pkg;

    // Datapath and field widths
    localparam int COORD_W = 32;
    localparam int FIELD_W = 32;
    localparam int TRIG_W  = 16;
    localparam int ZOOM_W  = 24;

    // Shared multiplier: coordinate by a 25-bit signed coefficient
    localparam int MUL_B_W = ZOOM_W + 1;
    localparam int PROD_W  = COORD_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    // Fixed-point fractions
    localparam int ZOOM_FRAC = 16;
    localparam int ROT_FRAC  = 14;
    localparam int COORD_FRAC = 16;

    // Screen mapping
    localparam int SCREEN_CX    = 320;
    localparam int SCREEN_CY    = 240;
    localparam int SCREEN_SCALE = 100;

    // Input queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // APB register map
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_COS_Y = 3'd0,
        REG_SIN_Y = 3'd1,
        REG_COS_X = 3'd2,
        REG_SIN_X = 3'd3,
        REG_ZOOM  = 3'd4
    } reg_idx_t;

    // Limits of the signed coordinate range, held at the wide sum width
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic signed [COORD_W-1:0] COORD_MAX = SAT_HI[COORD_W-1:0];
    localparam logic signed [COORD_W-1:0] COORD_MIN = SAT_LO[COORD_W-1:0];

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_y;
        logic signed [TRIG_W-1:0] sin_y;
        logic signed [TRIG_W-1:0] cos_x;
        logic signed [TRIG_W-1:0] sin_x;
        logic        [ZOOM_W-1:0] zoom;
    } cfg_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic                      last;
    } vtx_entry_t;

    typedef struct packed {
        logic       valid;
        vtx_entry_t entry;
    } q_link_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } front_stat_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

    // Clamp a wide signed value into the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = COORD_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/rpbb_vertex_if.sv */
// Vertex input channel: valid/ready with the vertex payload.
`default_nettype none

interface rpbb_vertex_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpbb_pkg::FIELD_W-1:0] vertex_x;
    logic signed [rpbb_pkg::FIELD_W-1:0] vertex_y;
    logic signed [rpbb_pkg::FIELD_W-1:0] vertex_z;
    logic                                 last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output last_vertex, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input last_vertex, output ready);
endinterface

`default_nettype wire

/* src/rpbb_box_if.sv */
// Box result channel: valid/ready with the bounding box payload.
`default_nettype none

interface rpbb_box_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpbb_pkg::FIELD_W-1:0] box_left;
    logic signed [rpbb_pkg::FIELD_W-1:0] box_top;
    logic        [rpbb_pkg::FIELD_W-1:0] box_width;
    logic        [rpbb_pkg::FIELD_W-1:0] box_height;

    modport source (output valid, output box_left, output box_top, output box_width,
                    output box_height, input ready);
    modport sink   (input valid, input box_left, input box_top, input box_width,
                    input box_height, output ready);
endinterface

`default_nettype wire

/* src/rpbb_regs.sv */
// APB configuration registers: rotation sines/cosines and zoom.
`default_nettype none

module rpbb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rpbb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready,
    output      rpbb_pkg::cfg_t               cfg
);

    rpbb_pkg::cfg_t     cfg_reg;
    rpbb_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = rpbb_pkg::reg_idx_t'(paddr[rpbb_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_y <= 16'sd16384;
            cfg_reg.sin_y <= '0;
            cfg_reg.cos_x <= 16'sd16384;
            cfg_reg.sin_x <= '0;
            cfg_reg.zoom  <= 24'd65536;
        end
        else if (wr_en)
        begin
            unique case (idx)
                rpbb_pkg::REG_COS_Y: cfg_reg.cos_y <= pwdata[rpbb_pkg::TRIG_W-1:0];
                rpbb_pkg::REG_SIN_Y: cfg_reg.sin_y <= pwdata[rpbb_pkg::TRIG_W-1:0];
                rpbb_pkg::REG_COS_X: cfg_reg.cos_x <= pwdata[rpbb_pkg::TRIG_W-1:0];
                rpbb_pkg::REG_SIN_X: cfg_reg.sin_x <= pwdata[rpbb_pkg::TRIG_W-1:0];
                rpbb_pkg::REG_ZOOM:  cfg_reg.zoom  <= pwdata[rpbb_pkg::ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            rpbb_pkg::REG_COS_Y: prdata = 32'($unsigned(cfg_reg.cos_y));
            rpbb_pkg::REG_SIN_Y: prdata = 32'($unsigned(cfg_reg.sin_y));
            rpbb_pkg::REG_COS_X: prdata = 32'($unsigned(cfg_reg.cos_x));
            rpbb_pkg::REG_SIN_X: prdata = 32'($unsigned(cfg_reg.sin_x));
            rpbb_pkg::REG_ZOOM:  prdata = 32'(cfg_reg.zoom);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/rpbb_front.sv */
// Front end: accepts vertex transfers, tags the last one and queues them for the back end.
`default_nettype none

module rpbb_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    rpbb_vertex_if.sink          vertex,
    output rpbb_pkg::q_link_t    link,
    input  wire logic            pop,
    output rpbb_pkg::front_stat_t stat
);

    rpbb_pkg::vtx_entry_t               slots [rpbb_pkg::QUEUE_DEPTH];
    logic [rpbb_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [rpbb_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [rpbb_pkg::QCNT_W-1:0]        count_reg;
    logic                               push;
    logic                               pull;
    rpbb_pkg::vtx_entry_t               in_entry;

    assign vertex.ready = (count_reg != rpbb_pkg::QCNT_W'(rpbb_pkg::QUEUE_DEPTH));
    assign push         = vertex.valid && vertex.ready;
    assign pull         = pop && (count_reg != '0);

    assign in_entry.x    = vertex.vertex_x;
    assign in_entry.y    = vertex.vertex_y;
    assign in_entry.z    = vertex.vertex_z;
    assign in_entry.last = vertex.last_vertex;

    assign link.valid = (count_reg != '0);
    assign link.entry = slots[rd_ptr_reg];
    assign stat.count = count_reg;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == rpbb_pkg::QPTR_W'(rpbb_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pull)
            begin
                rd_ptr_reg <= (rd_ptr_reg == rpbb_pkg::QPTR_W'(rpbb_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pull)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pull && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/rpbb_back.sv */
// Back end: zoom, rotate and project one vertex on a shared multiplier, track the box.
`default_nettype none

module rpbb_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rpbb_pkg::cfg_t   cfg,
    input  wire rpbb_pkg::q_link_t link,
    output logic                  pop,
    output rpbb_pkg::back_stat_t  stat,
    rpbb_box_if.source            box
);

    localparam int CW = rpbb_pkg::COORD_W;
    localparam int BW = rpbb_pkg::MUL_B_W;
    localparam int SW = rpbb_pkg::SUM_W;

    localparam logic signed [BW-1:0] SCALE_B = BW'(rpbb_pkg::SCREEN_SCALE);
    localparam logic signed [SW-1:0] CX_Q =
        SW'(rpbb_pkg::SCREEN_CX) <<< rpbb_pkg::COORD_FRAC;
    localparam logic signed [SW-1:0] CY_Q =
        SW'(rpbb_pkg::SCREEN_CY) <<< rpbb_pkg::COORD_FRAC;

    // States S_ZX to S_PY each issue one product; states S_ZY to S_PDONE each consume the one issued before
    typedef enum logic [3:0] {
        S_IDLE,
        S_ZX,
        S_ZY,
        S_ZZ,
        S_RX0,
        S_RX1,
        S_RZ0,
        S_RZ1,
        S_RY0,
        S_RY1,
        S_PX,
        S_PY,
        S_PDONE,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    logic signed [CW-1:0]         x_reg, y_reg, z_reg;
    logic                         last_reg;
    logic signed [CW-1:0]         vx_reg, vy_reg, vz_reg;
    logic signed [CW-1:0]         rx_reg, rz_reg, ry_reg;
    logic signed [CW-1:0]         sx_reg, sy_reg;
    logic signed [rpbb_pkg::PROD_W-1:0] acc_reg;
    logic signed [rpbb_pkg::PROD_W-1:0] prod_reg;
    logic signed [CW-1:0]         min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic                         out_valid_reg;
    logic signed [rpbb_pkg::FIELD_W-1:0] left_reg, top_reg;
    logic        [rpbb_pkg::FIELD_W-1:0] width_reg, height_reg;

    logic signed [CW-1:0]         mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [SW-1:0]         prod_ext;
    logic signed [SW-1:0]         acc_ext;
    logic signed [CW-1:0]         zoom_res;
    logic signed [CW-1:0]         rot_diff;
    logic signed [CW-1:0]         rot_sum;
    logic signed [CW-1:0]         proj_x;
    logic signed [CW-1:0]         proj_y;
    logic                         out_free;
    logic                         emit_now;

    assign pop       = (state_reg == S_IDLE) && link.valid;
    assign stat.busy = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || box.ready;
    assign emit_now  = (state_reg == S_EMIT) && last_reg && out_free;

    assign box.valid      = out_valid_reg;
    assign box.box_left   = left_reg;
    assign box.box_top    = top_reg;
    assign box.box_width  = width_reg;
    assign box.box_height = height_reg;

    // Multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_ZX:    begin mul_a = x_reg;  mul_b = BW'($signed({1'b0, cfg.zoom})); end
            S_ZY:    begin mul_a = y_reg;  mul_b = BW'($signed({1'b0, cfg.zoom})); end
            S_ZZ:    begin mul_a = z_reg;  mul_b = BW'($signed({1'b0, cfg.zoom})); end
            S_RX0:   begin mul_a = vx_reg; mul_b = BW'(cfg.cos_y); end
            S_RX1:   begin mul_a = vz_reg; mul_b = BW'(cfg.sin_y); end
            S_RZ0:   begin mul_a = vx_reg; mul_b = BW'(cfg.sin_y); end
            S_RZ1:   begin mul_a = vz_reg; mul_b = BW'(cfg.cos_y); end
            S_RY0:   begin mul_a = vy_reg; mul_b = BW'(cfg.cos_x); end
            S_RY1:   begin mul_a = rz_reg; mul_b = BW'(cfg.sin_x); end
            S_PX:    begin mul_a = rx_reg; mul_b = SCALE_B; end
            S_PY:    begin mul_a = ry_reg; mul_b = SCALE_B; end
            default: begin mul_a = '0;     mul_b = '0; end
        endcase
    end

    // Post-multiply arithmetic: floor shifts, combine and clamp
    always_comb
    begin
        prod_ext = SW'(prod_reg);
        acc_ext  = SW'(acc_reg);
        zoom_res = rpbb_pkg::sat_coord(prod_ext >>> rpbb_pkg::ZOOM_FRAC);
        rot_diff = rpbb_pkg::sat_coord((acc_ext - prod_ext) >>> rpbb_pkg::ROT_FRAC);
        rot_sum  = rpbb_pkg::sat_coord((acc_ext + prod_ext) >>> rpbb_pkg::ROT_FRAC);
        proj_x   = rpbb_pkg::sat_coord(CX_Q + prod_ext);
        proj_y   = rpbb_pkg::sat_coord(CY_Q - prod_ext);
    end

    // Sequencer, datapath registers, box accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            last_reg      <= 1'b0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            vz_reg        <= '0;
            rx_reg        <= '0;
            rz_reg        <= '0;
            ry_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            min_x_reg     <= rpbb_pkg::COORD_MAX;
            min_y_reg     <= rpbb_pkg::COORD_MAX;
            max_x_reg     <= rpbb_pkg::COORD_MIN;
            max_y_reg     <= rpbb_pkg::COORD_MIN;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            top_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            // Drain the output register unless a new box replaces it this cycle
            if (out_valid_reg && box.ready && !emit_now)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (link.valid)
                    begin
                        x_reg     <= CW'(link.entry.x);
                        y_reg     <= CW'(link.entry.y);
                        z_reg     <= CW'(link.entry.z);
                        last_reg  <= link.entry.last;
                        state_reg <= S_ZX;
                    end
                end
                S_ZX:    state_reg <= S_ZY;
                S_ZY:    begin vx_reg  <= zoom_res; state_reg <= S_ZZ;    end
                S_ZZ:    begin vy_reg  <= zoom_res; state_reg <= S_RX0;   end
                S_RX0:   begin vz_reg  <= zoom_res; state_reg <= S_RX1;   end
                S_RX1:   begin acc_reg <= prod_reg; state_reg <= S_RZ0;   end
                S_RZ0:   begin rx_reg  <= rot_diff; state_reg <= S_RZ1;   end
                S_RZ1:   begin acc_reg <= prod_reg; state_reg <= S_RY0;   end
                S_RY0:   begin rz_reg  <= rot_sum;  state_reg <= S_RY1;   end
                S_RY1:   begin acc_reg <= prod_reg; state_reg <= S_PX;    end
                S_PX:    begin ry_reg  <= rot_diff; state_reg <= S_PY;    end
                S_PY:    begin sx_reg  <= proj_x;   state_reg <= S_PDONE; end
                S_PDONE: begin sy_reg  <= proj_y;   state_reg <= S_ACC;   end
                S_ACC:
                begin
                    if (sx_reg < min_x_reg) min_x_reg <= sx_reg;
                    if (sy_reg < min_y_reg) min_y_reg <= sy_reg;
                    if (sx_reg > max_x_reg) max_x_reg <= sx_reg;
                    if (sy_reg > max_y_reg) max_y_reg <= sy_reg;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // Last vertex: once the output is free, publish the box and restart the accumulators
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        left_reg      <= rpbb_pkg::FIELD_W'(min_x_reg);
                        top_reg       <= rpbb_pkg::FIELD_W'(min_y_reg);
                        width_reg     <= rpbb_pkg::FIELD_W'(max_x_reg - min_x_reg);
                        height_reg    <= rpbb_pkg::FIELD_W'(max_y_reg - min_y_reg);
                        out_valid_reg <= 1'b1;
                        min_x_reg     <= rpbb_pkg::COORD_MAX;
                        min_y_reg     <= rpbb_pkg::COORD_MAX;
                        max_x_reg     <= rpbb_pkg::COORD_MIN;
                        max_y_reg     <= rpbb_pkg::COORD_MIN;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/rotated_projected_bounding_box.sv */
// Top level of the rotated, projected bounding box block.
// Vertices (signed Q16.16) arrive on the vertex channel and wait in a two-entry
// queue while the back end works on one vertex at a time: each is scaled by
// zoom_factor, rotated about Y then X with the programmed Q2.14 sine/cosine
// values, projected to screen as x = 320 + 100*rx, y = 240 - 100*ry, and folded
// into running min/max screen X and Y. In the back end a vertex is loaded,
// then passes through eleven products that share its single multiplier (one per
// cycle, registered) and the accumulate and publish steps; the front keeps
// taking vertices until the queue is full. On a vertex marked last, one result
// (left, top, width, height) is placed in the output register and the running
// box restarts; if the previous result is still waiting, the back end holds.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12, 16 and should be
// written only while the block is idle.
`default_nettype none

module rotated_projected_bounding_box (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    rpbb_vertex_if.sink                       vertex,
    rpbb_box_if.source                        box,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rpbb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready
);

    rpbb_pkg::cfg_t        cfg;
    rpbb_pkg::q_link_t     link;
    rpbb_pkg::front_stat_t front_stat;
    rpbb_pkg::back_stat_t  back_stat;
    logic                  back_pop;

    // Configuration registers
    rpbb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input acceptance and queue
    rpbb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex),
        .link   (link),
        .pop    (back_pop),
        .stat   (front_stat)
    );

    // Transform, projection and box tracking
    rpbb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .link  (link),
        .pop   (back_pop),
        .stat  (back_stat),
        .box   (box)
    );

`ifndef SYNTHESIS
    // Queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.count <= rpbb_pkg::QCNT_W'(rpbb_pkg::QUEUE_DEPTH))
        else $error("input queue fill level exceeds its depth");

    // A vertex taken from the queue starts the back-end sequence
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (link.valid && back_pop) |=> back_stat.busy)
        else $error("queue pop did not start the back end");

    // A result appears only at the end of a back-end sequence
    a_result_from_back: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(box.valid) |-> $past(back_stat.busy))
        else $error("result raised while back end was idle");
`endif

endmodule

`default_nettype wire
